### design/tccw_pkg.sv
`default_nettype none

package tccw_pkg;

    // Screen geometry
    localparam int COLS   = 80;
    localparam int ROWS   = 25;
    localparam int CELLS  = COLS * ROWS;

    // Field widths
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CHAR_W = 8;
    localparam int CELL_W = 16;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);

    // Character codes and attribute reset
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'h20;
    localparam logic [7:0]        ATTR_RESET   = 8'h0F;

    // Register map (word index)
    localparam logic REG_ATTR = 1'b0;

    typedef enum logic [1:0] {
        FUNC_PUT   = 2'd0,
        FUNC_CLEAR = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    // Controller -> datapath
    typedef struct packed {
        logic load_in;
        logic exec;
        logic blank_step;
        logic load_out;
    } tccw_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic blank_needed;
        logic blank_last;
        logic out_free;
    } tccw_status_t;

endpackage

`default_nettype wire

### design/tccw_ctrl.sv
`default_nettype none

module tccw_ctrl
    import tccw_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  tccw_status_t      status,
    output tccw_cmd_t         cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_BLANK,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && ready_reg) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = status.blank_needed ? ST_BLANK : ST_DONE;
            end
            ST_BLANK: begin
                cmd.blank_step = 1'b1;
                if (status.blank_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign s_tready = ready_reg;

endmodule

`default_nettype wire

### design/tccw_datapath.sv
`default_nettype none

module tccw_datapath
    import tccw_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  tccw_cmd_t         cmd,
    output tccw_status_t      status,
    input  wire logic [1:0]   s_tuser,
    input  wire logic [23:0]  s_tdata,
    input  wire logic [7:0]   attr,
    input  wire logic         m_tready,
    output logic              m_tvalid,
    output logic [31:0]       m_tdata
);

    localparam logic [ADDR_W-1:0] COLS_A   = ADDR_W'(COLS);
    localparam logic [ROW_W:0]    ROWS_X   = (ROW_W + 1)'(ROWS);
    localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(ROWS - 1);
    localparam logic [COL_W:0]    COLS_X   = (COL_W + 1)'(COLS);

    // Latched item
    func_t              func_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic [ROW_W-1:0]   rrow_reg;
    logic [COL_W-1:0]   rcol_reg;

    // Console state; top_reg is the physical row shown as logical row 0
    logic [ROW_W-1:0]   cur_row_reg, cur_row_next;
    logic [COL_W-1:0]   cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]   top_reg, top_next;
    logic [ADDR_W-1:0]  blank_addr_reg, blank_addr_next;
    logic [CNT_W-1:0]   blank_left_reg, blank_left_next;
    logic               scrolled_reg, scrolled_next;
    logic               out_valid_reg, out_valid_next;
    logic [CELL_W-1:0]  out_cell_reg;
    logic [ROW_W-1:0]   out_row_reg;
    logic [COL_W-1:0]   out_col_reg;
    logic               out_scr_reg;

    logic [CELL_W-1:0]  mem [CELLS];
    logic [CELL_W-1:0]  rd_data_reg;

    // Logical to physical row, modulo ROWS by one compare/subtract
    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] lrow,
                                                 input logic [ROW_W-1:0] top);
        logic [ROW_W:0] sum;
        sum = {1'b0, lrow} + {1'b0, top};
        if (sum >= ROWS_X) begin
            sum = sum - ROWS_X;
        end
        return sum[ROW_W-1:0];
    endfunction

    logic               is_put, is_clear, is_read;
    logic               nl;
    logic [COL_W:0]     col_inc;
    logic               row_adv;
    logic               need_scroll;
    logic               rd_in_range;
    logic [ADDR_W-1:0]  put_addr, rd_addr, top_addr;
    logic               put_wr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [CELL_W-1:0]  wr_data;

    assign is_put   = (func_reg == FUNC_PUT);
    assign is_clear = (func_reg == FUNC_CLEAR);
    assign is_read  = (func_reg == FUNC_READ);
    assign nl       = (char_reg == NEWLINE_CODE);
    assign col_inc  = {1'b0, cur_col_reg} + (COL_W + 1)'(1);
    assign row_adv  = nl || (col_inc >= COLS_X);
    assign need_scroll = is_put && row_adv && (cur_row_reg == LAST_ROW);
    assign rd_in_range = ({1'b0, rrow_reg} < ROWS_X) && ({1'b0, rcol_reg} < COLS_X);

    assign put_addr = ADDR_W'(phys_row(cur_row_reg, top_reg)) * COLS_A
                    + ADDR_W'(cur_col_reg);
    assign rd_addr  = ADDR_W'(phys_row(rrow_reg, top_reg)) * COLS_A
                    + ADDR_W'(rcol_reg);
    assign top_addr = ADDR_W'(top_reg) * COLS_A;

    assign put_wr  = cmd.exec && is_put && !nl;
    assign wr_en   = put_wr || cmd.blank_step;
    assign wr_addr = cmd.blank_step ? blank_addr_reg : put_addr;
    assign wr_data = cmd.blank_step ? {attr, BLANK_CODE} : {attr, char_reg};

    always_comb begin
        cur_row_next    = cur_row_reg;
        cur_col_next    = cur_col_reg;
        top_next        = top_reg;
        blank_addr_next = blank_addr_reg;
        blank_left_next = blank_left_reg;
        scrolled_next   = scrolled_reg;
        out_valid_next  = out_valid_reg;

        if (cmd.load_in) begin
            scrolled_next = 1'b0;
        end

        if (cmd.exec) begin
            if (is_put) begin
                cur_col_next = row_adv ? '0 : col_inc[COL_W-1:0];
                if (need_scroll) begin
                    // Old top row becomes the new bottom line
                    top_next        = (top_reg == LAST_ROW) ? '0 : top_reg + ROW_W'(1);
                    blank_addr_next = top_addr;
                    blank_left_next = CNT_W'(COLS);
                    scrolled_next   = 1'b1;
                end else if (row_adv) begin
                    cur_row_next = cur_row_reg + ROW_W'(1);
                end
            end else if (is_clear) begin
                cur_row_next    = '0;
                cur_col_next    = '0;
                top_next        = '0;
                blank_addr_next = '0;
                blank_left_next = CNT_W'(CELLS);
            end
        end

        if (cmd.blank_step) begin
            blank_addr_next = blank_addr_reg + ADDR_W'(1);
            blank_left_next = blank_left_reg - CNT_W'(1);
        end

        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_row_reg    <= '0;
            cur_col_reg    <= '0;
            top_reg        <= '0;
            blank_left_reg <= '0;
            scrolled_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            cur_row_reg    <= cur_row_next;
            cur_col_reg    <= cur_col_next;
            top_reg        <= top_next;
            blank_left_reg <= blank_left_next;
            scrolled_reg   <= scrolled_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        blank_addr_reg <= blank_addr_next;
        if (cmd.load_in) begin
            func_reg <= func_t'(s_tuser);
            char_reg <= s_tdata[7:0];
            rrow_reg <= s_tdata[12:8];
            rcol_reg <= s_tdata[19:13];
        end
        if (cmd.load_out) begin
            out_cell_reg <= (is_read && rd_in_range) ? rd_data_reg : '0;
            out_row_reg  <= cur_row_reg;
            out_col_reg  <= cur_col_reg;
            out_scr_reg  <= scrolled_reg;
        end
    end

    // Cell memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.exec) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign status.blank_needed = is_clear || need_scroll;
    assign status.blank_last   = (blank_left_reg == CNT_W'(1));
    assign status.out_free     = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_scr_reg, out_col_reg, out_row_reg, out_cell_reg};

    a_cursor_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, cur_row_reg} < ROWS_X) && ({1'b0, cur_col_reg} < COLS_X))
        else $error("cursor outside the screen");

    a_top_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, top_reg} < ROWS_X))
        else $error("row offset outside the screen");

    a_single_writer: assert property (@(posedge aclk) disable iff (!aresetn)
        !(put_wr && cmd.blank_step))
        else $error("put and blank write in the same cycle");

    a_blank_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.blank_step |-> (blank_left_reg != '0))
        else $error("blank sweep ran past its count");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=> (out_valid_reg && $stable(m_tdata)))
        else $error("pending result lost or changed");

endmodule

`default_nettype wire

### design/text_console_cell_writer_unit.sv
// Sequence: an accepted item is latched, executed, and its result handed to the output register.
// A put that scrolls adds a sweep that blanks the new bottom line (COLS cells, 80); a clear
// blanks all ROWS*COLS cells (2000). One item is in work at a time, so a new item is taken
// only after the last result is handed on; the single write port paces the blanking sweep.
// Reset (aresetn low, synchronous): cursor home, no pending transaction, attribute 0x0F;
// cell contents stay undefined until written, no clearing pass.
`default_nettype none

module text_console_cell_writer_unit
    import tccw_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,

    // Input channel
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [23:0]  s_tdata,   // char_code[7:0], read_row[12:8], read_col[19:13]
    input  wire logic [1:0]   s_tuser,   // func[1:0]

    // Result channel
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [31:0]       m_tdata,   // cell_value[15:0], cursor_row[20:16],
                                         // cursor_col[27:21], scrolled[28]

    // Configuration port
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    tccw_cmd_t    cmd;
    tccw_status_t status;
    logic [7:0]   attr_reg;
    logic         cfg_wr;

    // Register write completes on the access phase; pready is tied high
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ATTR);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg <= ATTR_RESET;
        end else if (cfg_wr) begin
            attr_reg <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[2] == REG_ATTR) ? {24'd0, attr_reg} : 32'd0;

    // Sequencer: accept, execute, optional blanking sweep, hand result to output register
    tccw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Cursor, scroll offset, cell memory and output register
    tccw_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .attr     (attr_reg),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

### tb/sv/console_result_checker.sv
`timescale 1ns / 1ps

module console_result_checker
    import tccw_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [23:0]  s_tdata,   // char_code[7:0], read_row[12:8], read_col[19:13]
    input  wire logic [1:0]   s_tuser,   // func[1:0]
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [31:0]  m_tdata,   // cell_value[15:0], cursor_row[20:16],
                                         // cursor_col[27:21], scrolled[28]
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    input  wire logic [31:0]  prdata,
    input  wire logic         pready,
    output int                mismatches,
    output int                outstanding
);

    localparam logic [2:0] ATTR_ADDR = {REG_ATTR, 2'b00};

    // Same bit layout as m_tdata
    typedef struct packed {
        logic [2:0]        pad;
        logic              scrolled;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [CELL_W-1:0] cell_value;
    } console_result_t;

    logic [CELL_W-1:0] screen [ROWS][COLS];
    int                cur_row;
    int                cur_col;
    logic [7:0]        attr;
    console_result_t   awaited_q [$];
    console_result_t   got;
    console_result_t   want;
    int                results_seen;

    task automatic note_mismatch(string what, logic [31:0] seen, logic [31:0] wanted);
        $display("%0t: mismatch in %s after %0d results: got %0h, want %0h",
                 $time, what, results_seen, seen, wanted);
        mismatches++;
    endtask

    function automatic console_result_t console_step(func_t f, logic [7:0] ch,
                                                     logic [4:0] rr, logic [6:0] rc);
        console_result_t r;
        int x;
        int y;
        r = '0;
        case (f)
            FUNC_PUT: begin
                if (ch == NEWLINE_CODE) begin
                    cur_col = 0;
                    cur_row++;
                end else begin
                    if (cur_row < ROWS && cur_col < COLS)
                        screen[cur_row][cur_col] = {attr, ch};
                    cur_col++;
                    if (cur_col >= COLS) begin
                        cur_col = 0;
                        cur_row++;
                    end
                end
                // past the bottom line: move everything up, blank the new bottom line
                if (cur_row >= ROWS) begin
                    for (y = 0; y < ROWS - 1; y++)
                        for (x = 0; x < COLS; x++)
                            screen[y][x] = screen[y + 1][x];
                    for (x = 0; x < COLS; x++)
                        screen[ROWS - 1][x] = {attr, BLANK_CODE};
                    cur_row = ROWS - 1;
                    r.scrolled = 1'b1;
                end
            end
            FUNC_CLEAR: begin
                for (y = 0; y < ROWS; y++)
                    for (x = 0; x < COLS; x++)
                        screen[y][x] = {attr, BLANK_CODE};
                cur_row = 0;
                cur_col = 0;
            end
            FUNC_READ: begin
                if (rr < ROWS && rc < COLS)
                    r.cell_value = screen[rr][rc];
            end
            default: ;
        endcase
        r.row = ROW_W'(cur_row);
        r.col = COL_W'(cur_col);
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            cur_row = 0;
            cur_col = 0;
            attr    = ATTR_RESET;
            awaited_q.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == ATTR_ADDR)
                attr = pwdata[7:0];
            if (psel && penable && !pwrite && pready && paddr == ATTR_ADDR &&
                prdata !== {24'b0, attr})
                note_mismatch("attribute readback", prdata, {24'b0, attr});

            if (s_tvalid && s_tready)
                awaited_q.push_back(console_step(func_t'(s_tuser), s_tdata[7:0],
                                                 s_tdata[12:8], s_tdata[19:13]));

            if (m_tvalid && m_tready) begin
                if (awaited_q.size() == 0) begin
                    note_mismatch("unexpected transaction", m_tdata, '0);
                end else begin
                    want = awaited_q.pop_front();
                    got  = console_result_t'(m_tdata);
                    if (got.cell_value !== want.cell_value)
                        note_mismatch("cell_value", 32'(got.cell_value),
                                      32'(want.cell_value));
                    if (got.row !== want.row)
                        note_mismatch("cursor_row", 32'(got.row), 32'(want.row));
                    if (got.col !== want.col)
                        note_mismatch("cursor_col", 32'(got.col), 32'(want.col));
                    if (got.scrolled !== want.scrolled)
                        note_mismatch("scrolled", 32'(got.scrolled), 32'(want.scrolled));
                    if (got.pad !== want.pad)
                        note_mismatch("tdata padding", 32'(got.pad), 32'(want.pad));
                    results_seen++;
                end
            end
        end
        outstanding = awaited_q.size();
    end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import tccw_pkg::*;

    localparam logic [2:0] ATTR_ADDR      = {REG_ATTR, 2'b00};
    // Slowest legal run is roughly every transaction a clear plus receiver stalls;
    // this leaves plenty of room above that.
    localparam int         LIMIT_CYCLES   = 6_000_000;
    localparam int         PHASE_ITEMS    = 140;
    localparam int         SETTLE_CYCLES  = 8;
    localparam int         HOLD_CYCLES    = 300;  // long receiver stall under pressure

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [23:0] s_tdata  = '0;   // char_code[7:0], read_row[12:8], read_col[19:13]
    logic [1:0]  s_tuser  = '0;   // func[1:0]
    logic        m_tready = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    wire logic        s_tready;
    wire logic        m_tvalid;
    wire logic [31:0] m_tdata;    // cell_value[15:0], cursor_row[20:16],
                                  // cursor_col[27:21], scrolled[28]
    wire logic [31:0] prdata;
    wire logic        pready;

    int   mismatches;
    int   outstanding;
    int   items_sent   = 0;
    int   tx_idle_pct  = 0;
    int   rx_idle_pct  = 0;
    int   cycle_count  = 0;
    logic rx_hold      = 1'b0;
    logic pressure_arm = 1'b0;

    text_console_cell_writer_unit DUT (.*);

    console_result_checker result_check (.*);

    // 12 ns clock
    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // Watchdog: a hung handshake or a lost result ends here
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side backpressure; rx_hold overrides the random stalls
    always @(negedge aclk)
        m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);

    // Long receiver stall once armed: the block fills up and must drop s_tready
    // while the sender keeps offering.
    initial begin
        wait (pressure_arm);
        @(posedge aclk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold = 1'b0;
    end

    // One input transaction; random idle cycles ahead of it, valid stays high
    // straight into the next transaction when no idle is drawn.
    task automatic offer(func_t f, logic [7:0] ch, logic [4:0] rr, logic [6:0] rc);
        @(negedge aclk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {4'b0, rc, rr, ch};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // Unused fields get random content so their input bits toggle
    task automatic put_char(logic [7:0] ch);
        offer(FUNC_PUT, ch, 5'($urandom), 7'($urandom));
    endtask

    task automatic read_cell(logic [4:0] rr, logic [6:0] rc);
        offer(FUNC_READ, 8'($urandom), rr, rc);
    endtask

    task automatic apb_access(logic wr, logic [2:0] addr, logic [31:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write the attribute and read it straight back (checker compares prdata)
    task automatic set_attribute(logic [7:0] value);
        apb_access(1'b1, ATTR_ADDR, {24'b0, value});
        apb_access(1'b0, ATTR_ADDR, '0);
    endtask

    // Drop valid and wait for every expected result; the block is idle after that
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Random traffic shaped like console text: mostly short lines ending in
    // newline, sometimes long lines that wrap, reads sprinkled in, plus rare
    // clears, no-ops and noise with fully random fields.
    task automatic run_phase(int n);
        int         stop_at;
        int         pick;
        int         len;
        int         k;
        logic [7:0] ch;
        stop_at = items_sent + n;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(170, 60) : $urandom_range(8);
                for (k = 0; k < len; k++) begin
                    if ($urandom_range(9) == 0)
                        read_cell(5'($urandom_range(ROWS - 1)), 7'($urandom_range(COLS - 1)));
                    ch = 8'($urandom_range(255));
                    if (ch == NEWLINE_CODE)
                        ch = BLANK_CODE;
                    put_char(ch);
                end
                if ($urandom_range(4) != 0)
                    put_char(NEWLINE_CODE);
            end else if (pick < 88) begin
                repeat ($urandom_range(3, 1))
                    read_cell(5'($urandom_range(ROWS - 1)), 7'($urandom_range(COLS - 1)));
            end else if (pick < 92) begin
                offer(FUNC_NOP, 8'($urandom), 5'($urandom), 7'($urandom));
            end else if (pick < 93) begin
                offer(FUNC_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom));
            end else if ($urandom_range(1) == 0) begin
                put_char(8'($urandom));
            end else begin
                // any row/col code, out-of-range ones included
                read_cell(5'($urandom), 7'($urandom));
            end
        end
    endtask

    initial begin
        int i;

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        tx_idle_pct = 20;
        rx_idle_pct = 69;

        // attribute must come out of reset as 0x0F
        apb_access(1'b0, ATTR_ADDR, '0);

        // Directed: before the first clear only transactions that touch no cell
        offer(FUNC_NOP, 8'hFF, 5'h1F, 7'h7F);
        read_cell(5'h1F, 7'h7F);                // out of range on both axes
        offer(FUNC_CLEAR, 8'h00, 5'h00, 7'h00);
        read_cell(5'd0, 7'd0);                  // blank cell
        read_cell(5'(ROWS - 1), 7'(COLS - 1));  // last cell
        read_cell(5'(ROWS), 7'd0);              // row just out of range
        read_cell(5'd0, 7'(COLS));              // column just out of range
        put_char(8'h41);
        put_char(8'h00);                        // zero byte is a plain character
        put_char(8'hFF);
        put_char(8'h0D);                        // control byte other than newline
        put_char(NEWLINE_CODE);
        put_char(8'h7E);
        for (i = 0; i < 5; i++)
            read_cell(5'd0, 7'(i));
        read_cell(5'd1, 7'd0);
        read_cell(5'd1, 7'd1);
        put_char(NEWLINE_CODE);
        settle();

        // Phase 1: sender idles 20%, receiver 69%, attribute all ones
        set_attribute(8'hFF);
        run_phase(PHASE_ITEMS);
        settle();

        // Phase 2: roles swapped, attribute all zeros
        tx_idle_pct = 69;
        rx_idle_pct = 20;
        set_attribute(8'h00);
        run_phase(PHASE_ITEMS);
        settle();

        // Phase 3: full rate, random attribute, long receiver stall at the start
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_attribute(8'($urandom_range(254, 1)));
        pressure_arm = 1'b1;
        run_phase(PHASE_ITEMS);
        settle();

        if (mismatches == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
